// ===== rtl/core/acd_pkg.sv =====
// ----------------------------------------------------------------------------
// acd_pkg
// Shared constants and types for the atom clash detector.
// ----------------------------------------------------------------------------
package acd_pkg;

    localparam int ACD_MAX_REF_ATOMS = 1024;

    localparam int COORD_W     = 25;
    localparam int SERIAL_W    = 17;
    localparam int RADIUS_W    = 16;
    localparam int R2_W        = 2 * RADIUS_W;
    localparam int QCOMP_W     = 11;
    localparam int QCOMP_MAX   = 2 ** QCOMP_W - 1;
    localparam int CLASH_TOT_W = 32;
    localparam int COMP_TOT_W  = 48;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 2;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd4000;

    // distance pipeline depth: abs diff, square, sum, compare
    localparam int DIST_LAT = 4;
    localparam int DRAIN_W  = $clog2(DIST_LAT + 1);

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_QUERY = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } atom_t;

    typedef struct packed {
        logic vld;
        logic counted;
    } dist_tag_t;

    typedef struct packed {
        logic vld;
        logic counted;
        logic hit;
    } dist_res_t;

endpackage

// ===== rtl/core/acd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// acd_cfg_if
// Configuration write channel: clash radius.
// ----------------------------------------------------------------------------
interface acd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] clash_radius;

    modport source (output valid, output clash_radius, input ready);
    modport sink   (input valid, input clash_radius, output ready);
endinterface

// ===== rtl/core/acd_in_if.sv =====
// ----------------------------------------------------------------------------
// acd_in_if
// Request channel: clear, load or query items.
// ----------------------------------------------------------------------------
interface acd_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [24:0] coord_x;
    logic signed [24:0] coord_y;
    logic signed [24:0] coord_z;
    logic [16:0]        atom_serial;

    modport source (output valid, output func, output coord_x, output coord_y,
                    output coord_z, output atom_serial, input ready);
    modport sink   (input valid, input func, input coord_x, input coord_y,
                    input coord_z, input atom_serial, output ready);
endinterface

// ===== rtl/core/acd_out_if.sv =====
// ----------------------------------------------------------------------------
// acd_out_if
// Result channel: one transfer per query.
// ----------------------------------------------------------------------------
interface acd_out_if;
    logic        valid;
    logic        ready;
    logic        clashed;
    logic [10:0] query_comparisons;
    logic [16:0] serial_echo;
    logic [31:0] total_clashes;
    logic [47:0] total_comparisons;

    modport source (output valid, output clashed, output query_comparisons,
                    output serial_echo, output total_clashes,
                    output total_comparisons, input ready);
    modport sink   (input valid, input clashed, input query_comparisons,
                    input serial_echo, input total_clashes,
                    input total_comparisons, output ready);
endinterface

// ===== rtl/core/atom_clash_detector_core.sv =====
// ----------------------------------------------------------------------------
// atom_clash_detector_core
// Fixed-radius clash search of a query atom against stored reference atoms.
// ----------------------------------------------------------------------------
// Reference atoms sit in a ring of MAX_REF_ATOMS identical cells. A load
// transfer shifts the ring one place and enters the new atom at the tail, so
// the atoms stay in load order at the top of the ring; a load into a full
// store is dropped. Clear and load leave the block idle and give no result.
// A query rotates the whole ring once past a single distance pipeline, then
// drains the pipeline and posts the result; posting waits only while the
// previous result still waits in the output register. The rotation length,
// not the store fill, sets the query time; cells that hold no loaded atom
// are passed through but not counted, and compares after the first clash
// are ignored. The result sits in an output register, so the next request
// is taken while it still waits for its transfer. The radius may be written
// any time the block is idle; its square is latched per query.
// ----------------------------------------------------------------------------
module atom_clash_detector_core
    import acd_pkg::*;
#(
    parameter int MAX_REF_ATOMS = ACD_MAX_REF_ATOMS
)
(
    input  logic       clk,
    input  logic       rst_n,
    acd_cfg_if.sink    cfg,
    acd_in_if.sink     req,
    acd_out_if.source  rsp
);

    localparam int CNT_W = $clog2(MAX_REF_ATOMS + 1);
    localparam int IDX_W = (MAX_REF_ATOMS > 1) ? $clog2(MAX_REF_ATOMS) : 1;

    // control
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       step_reg, step_next;
    logic [DRAIN_W-1:0]     drain_reg, drain_next;
    logic                   ring_rotate;
    logic                   done_fire;

    // store fill and radius
    logic [CNT_W-1:0]       count_reg;
    logic [RADIUS_W-1:0]    radius_reg;
    logic [R2_W-1:0]        r2_reg;

    // query context
    atom_t                  q_atom_reg;
    logic [SERIAL_W-1:0]    serial_reg;
    logic                   hit_found_reg;
    logic [CNT_W-1:0]       qcnt_reg;

    // running totals
    logic [CLASH_TOT_W-1:0] clash_tot_reg, clash_tot_next;
    logic [COMP_TOT_W-1:0]  comp_tot_reg, comp_tot_next;
    logic [COMP_TOT_W:0]    comp_sum;
    logic [QCOMP_W-1:0]     qcomp_sat;

    // result register
    logic                   rsp_valid_reg;
    logic                   clashed_reg;
    logic [QCOMP_W-1:0]     qcomp_reg;
    logic [SERIAL_W-1:0]    serial_echo_reg;
    logic [CLASH_TOT_W-1:0] total_clashes_reg;
    logic [COMP_TOT_W-1:0]  total_comp_reg;

    // request decode
    func_t                  in_func;
    logic                   in_fire;
    logic                   clear_fire;
    logic                   load_fire;
    logic                   query_fire;
    logic                   out_free;
    atom_t                  in_atom;

    // ring and distance unit
    atom_t                  cell_out [MAX_REF_ATOMS];
    atom_t                  tail_in;
    logic                   shift_en;
    dist_tag_t              issue_tag;
    dist_res_t              dist_res;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);

    assign in_fire    = req.valid && req.ready;
    assign in_func    = func_t'(req.func);
    assign clear_fire = in_fire && (in_func == FUNC_CLEAR);
    assign query_fire = in_fire && (in_func == FUNC_QUERY);
    // a full store ignores further loads
    assign load_fire  = in_fire && (in_func == FUNC_LOAD)
                        && (count_reg != CNT_W'(MAX_REF_ATOMS));
    assign out_free   = !rsp_valid_reg || rsp.ready;

    assign in_atom.x = req.coord_x;
    assign in_atom.y = req.coord_y;
    assign in_atom.z = req.coord_z;

    // ------------------------------------------------------------------------
    // Sequencer: IDLE -> SCAN (one full ring turn) -> DRAIN -> DONE
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        drain_next  = drain_reg;
        ring_rotate = 1'b0;
        done_fire   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_fire)
                begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                end
            end
            ST_SCAN:
            begin
                ring_rotate = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == IDX_W'(MAX_REF_ATOMS - 1))
                begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_W'(DIST_LAT - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    done_fire  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Reference ring. Cell 0 is the head seen by the distance unit; on a turn
    // the head wraps to the tail, on a load the new atom enters the tail.
    // ------------------------------------------------------------------------
    assign shift_en = ring_rotate || load_fire;
    assign tail_in  = ring_rotate ? cell_out[0] : in_atom;

    for (genvar i = 0; i < MAX_REF_ATOMS; i++)
    begin : g_cell
        atom_t cell_in;
        if (i == MAX_REF_ATOMS - 1)
        begin : g_tail
            assign cell_in = tail_in;
        end
        else
        begin : g_body
            assign cell_in = cell_out[i+1];
        end

        acd_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .din      (cell_in),
            .dout     (cell_out[i])
        );
    end

    // loaded atoms occupy the last count_reg cells, oldest first
    assign issue_tag.vld     = ring_rotate;
    assign issue_tag.counted = CNT_W'(step_reg) >= (CNT_W'(MAX_REF_ATOMS) - count_reg);

    acd_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (q_atom_reg),
        .refatom (cell_out[0]),
        .r2      (r2_reg),
        .tag     (issue_tag),
        .res     (dist_res)
    );

    // ------------------------------------------------------------------------
    // Radius, fill count, per-query tally
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            radius_reg <= cfg.clash_radius;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_fire)
        begin
            q_atom_reg <= in_atom;
            serial_reg <= req.atom_serial;
            r2_reg     <= R2_W'(radius_reg) * R2_W'(radius_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (clear_fire)
        begin
            count_reg <= '0;
        end
        else if (load_fire)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // stop counting after the first clash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg <= 1'b0;
            qcnt_reg      <= '0;
        end
        else if (query_fire)
        begin
            hit_found_reg <= 1'b0;
            qcnt_reg      <= '0;
        end
        else if (dist_res.vld && dist_res.counted && !hit_found_reg)
        begin
            qcnt_reg <= qcnt_reg + 1'b1;
            if (dist_res.hit)
            begin
                hit_found_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Saturating totals and result register
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (hit_found_reg && (clash_tot_reg != '1))
        begin
            clash_tot_next = clash_tot_reg + 1'b1;
        end
        else
        begin
            clash_tot_next = clash_tot_reg;
        end

        comp_sum = {1'b0, comp_tot_reg} + (COMP_TOT_W + 1)'(qcnt_reg);
        if (comp_sum[COMP_TOT_W])
        begin
            comp_tot_next = '1;
        end
        else
        begin
            comp_tot_next = comp_sum[COMP_TOT_W-1:0];
        end

        if (32'(qcnt_reg) > 32'(QCOMP_MAX))
        begin
            qcomp_sat = QCOMP_W'(QCOMP_MAX);
        end
        else
        begin
            qcomp_sat = QCOMP_W'(qcnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clash_tot_reg <= '0;
            comp_tot_reg  <= '0;
        end
        else if (clear_fire)
        begin
            clash_tot_reg <= '0;
            comp_tot_reg  <= '0;
        end
        else if (done_fire)
        begin
            clash_tot_reg <= clash_tot_next;
            comp_tot_reg  <= comp_tot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            clashed_reg       <= hit_found_reg;
            qcomp_reg         <= qcomp_sat;
            serial_echo_reg   <= serial_reg;
            total_clashes_reg <= clash_tot_next;
            total_comp_reg    <= comp_tot_next;
        end
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.clashed           = clashed_reg;
    assign rsp.query_comparisons = qcomp_reg;
    assign rsp.serial_echo       = serial_echo_reg;
    assign rsp.total_clashes     = total_clashes_reg;
    assign rsp.total_comparisons = total_comp_reg;

endmodule

// ===== rtl/core/acd_cell.sv =====
// ----------------------------------------------------------------------------
// acd_cell
// One slot of the reference atom ring; takes its neighbor's atom on shift.
// ----------------------------------------------------------------------------
module acd_cell
    import acd_pkg::*;
(
    input  logic  clk,
    input  logic  shift_en,
    input  atom_t din,
    output atom_t dout
);

    atom_t atom_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            atom_reg <= din;
        end
    end

    assign dout = atom_reg;

endmodule

// ===== rtl/core/acd_dist.sv =====
// ----------------------------------------------------------------------------
// acd_dist
// Four-stage squared distance and strict less-than compare.
// ----------------------------------------------------------------------------
module acd_dist
    import acd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  atom_t           query,
    input  atom_t           refatom,
    input  logic [R2_W-1:0] r2,
    input  dist_tag_t       tag,
    output dist_res_t       res
);

    logic signed [COORD_W:0] dx, dy, dz;
    logic signed [COORD_W:0] nx, ny, nz;
    logic [COORD_W-1:0]      ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0]       sum_reg;
    dist_tag_t               tag1_reg, tag2_reg, tag3_reg;
    dist_res_t               res_reg;

    // stage 1: absolute coordinate differences
    always_comb
    begin
        dx = {query.x[COORD_W-1], query.x} - {refatom.x[COORD_W-1], refatom.x};
        dy = {query.y[COORD_W-1], query.y} - {refatom.y[COORD_W-1], refatom.y};
        dz = {query.z[COORD_W-1], query.z} - {refatom.z[COORD_W-1], refatom.z};
        nx = dx[COORD_W] ? -dx : dx;
        ny = dy[COORD_W] ? -dy : dy;
        nz = dz[COORD_W] ? -dz : dz;
    end

    always_ff @(posedge clk)
    begin
        ax_reg  <= nx[COORD_W-1:0];
        ay_reg  <= ny[COORD_W-1:0];
        az_reg  <= nz[COORD_W-1:0];
        // stage 2: squares
        sqx_reg <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sqy_reg <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        sqz_reg <= SQ_W'(az_reg) * SQ_W'(az_reg);
        // stage 3: sum
        sum_reg <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            tag1_reg        <= tag;
            tag2_reg        <= tag1_reg;
            tag3_reg        <= tag2_reg;
            // stage 4: compare
            res_reg.vld     <= tag3_reg.vld;
            res_reg.counted <= tag3_reg.counted;
            res_reg.hit     <= sum_reg < DIST_W'(r2);
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/acd_checker.sv =====
// ----------------------------------------------------------------------------
// acd_checker
// Port-level checks for the atom clash detector, bound to the top level.
// ----------------------------------------------------------------------------
module acd_checker
    import acd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [1:0]  req_func,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_clashed,
    input logic [10:0] rsp_query_comparisons,
    input logic [16:0] rsp_serial_echo,
    input logic [31:0] rsp_total_clashes
);

    logic req_fire;

    assign req_fire = req_valid && req_ready;

    // a stalled result stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_serial_echo))
        else $error("stalled result changed");

    // a query occupies the block for the ring turn
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req_func == FUNC_QUERY) |=> !req_ready)
        else $error("request taken right after a query");

    // clear and load leave the block ready for another request
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && ((req_func == FUNC_CLEAR) || (req_func == FUNC_LOAD))
        |=> req_ready)
        else $error("block busy after clear or load");

    // a clash counts at least the clashing atom and the running total
    a_clash_counts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_clashed |->
        (rsp_query_comparisons != 11'd0) && (rsp_total_clashes != 32'd0))
        else $error("clash reported with zero counts");

endmodule

bind atom_clash_detector_core acd_checker u_acd_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .req_valid             (req.valid),
    .req_ready             (req.ready),
    .req_func              (req.func),
    .rsp_valid             (rsp.valid),
    .rsp_ready             (rsp.ready),
    .rsp_clashed           (rsp.clashed),
    .rsp_query_comparisons (rsp.query_comparisons),
    .rsp_serial_echo       (rsp.serial_echo),
    .rsp_total_clashes     (rsp.total_clashes)
);

// ===== tb/tb_atom_clash_detector_core.sv =====
// ----------------------------------------------------------------------------
// tb_atom_clash_detector_core
// Self-checking bench for the clash detector: a table of directed vectors,
// a grid of reference atoms, then random clear/load/query traffic. Every query
// result is checked against its table entry or a predicted search result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_atom_clash_detector_core;
    import acd_pkg::*;

    // func code 3 has no meaning; the block must swallow it without a result
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 455;
    localparam int GRID_ATOMS   = 64;
    // a query rotates the full ring, then drains the pipeline
    localparam int SETTLE_CYCLES  = ACD_MAX_REF_ATOMS + 8;
    // longest legal stretch with no transfer is one query or one settle wait
    localparam int WATCHDOG_LIMIT = 8 * SETTLE_CYCLES;

    localparam logic [CLASH_TOT_W-1:0] CLASH_TOT_MAX = '1;
    localparam logic [COMP_TOT_W-1:0]  COMP_TOT_MAX  = '1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SERIAL_W-1:0]       serial_t;

    typedef struct {
        bit                   clashed;
        bit [QCOMP_W-1:0]     comparisons;
        bit [SERIAL_W-1:0]    serial;
        bit [CLASH_TOT_W-1:0] clash_total;
        bit [COMP_TOT_W-1:0]  comp_total;
    } clash_report_t;

    typedef struct {
        logic [1:0]    fn;
        int            x;
        int            y;
        int            z;
        int            serial;
        bit            has_want;
        clash_report_t want;
    } vector_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    acd_cfg_if cfg_ch ();
    acd_in_if  req_ch ();
    acd_out_if rsp_ch ();

    atom_clash_detector_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted state: the store in load order, fill count, totals and
    // the radius as last written.
    // ------------------------------------------------------------------
    longint                 atom_x [ACD_MAX_REF_ATOMS];
    longint                 atom_y [ACD_MAX_REF_ATOMS];
    longint                 atom_z [ACD_MAX_REF_ATOMS];
    int                     atom_count    = 0;
    logic [CLASH_TOT_W-1:0] clash_total_m = '0;
    logic [COMP_TOT_W-1:0]  comp_total_m  = '0;
    logic [RADIUS_W-1:0]    radius_m      = RADIUS_RESET;

    clash_report_t pending_reports [$];
    vector_row_t   vectors [$];
    clash_report_t no_want;

    int mismatches  = 0;
    int idle_cycles = 0;
    int tx_calm     = 0;
    int rx_calm     = 0;

    // Applies one accepted item to the predicted state. Returns 1 and the
    // expected report for a query, 0 for everything else.
    function automatic bit predict_clash(input logic [1:0] fn, input coord_t x, y, z,
                                         input serial_t serial,
                                         output clash_report_t rep);
        longint r2;
        longint d2;
        longint dx;
        longint dy;
        longint dz;
        int     n;
        bit     hit;
        rep = '{default: 0};
        case (fn)
            FUNC_CLEAR:
            begin
                atom_count    = 0;
                clash_total_m = '0;
                comp_total_m  = '0;
                return 1'b0;
            end
            FUNC_LOAD:
            begin
                // a load into a full store is dropped
                if (atom_count < ACD_MAX_REF_ATOMS)
                begin
                    atom_x[atom_count] = longint'(x);
                    atom_y[atom_count] = longint'(y);
                    atom_z[atom_count] = longint'(z);
                    atom_count++;
                end
                return 1'b0;
            end
            FUNC_QUERY:
            begin
                r2  = longint'(radius_m) * longint'(radius_m);
                n   = 0;
                hit = 1'b0;
                // walk in load order, stop at the first strict hit
                for (int i = 0; i < atom_count; i++)
                begin
                    dx = longint'(x) - atom_x[i];
                    dy = longint'(y) - atom_y[i];
                    dz = longint'(z) - atom_z[i];
                    d2 = dx * dx + dy * dy + dz * dz;
                    n++;
                    if (d2 < r2)
                    begin
                        hit = 1'b1;
                        break;
                    end
                end
                if (hit && clash_total_m != CLASH_TOT_MAX)
                    clash_total_m++;
                if (COMP_TOT_MAX - comp_total_m < n)
                    comp_total_m = COMP_TOT_MAX;
                else
                    comp_total_m += n;
                rep.clashed     = hit;
                rep.comparisons = QCOMP_W'((n > QCOMP_MAX) ? QCOMP_MAX : n);
                rep.serial      = serial;
                rep.clash_total = clash_total_m;
                rep.comp_total  = comp_total_m;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Per-item wait drawn at random, with occasional calm runs of no waiting.
    function automatic int draw_idle(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly within the documented coordinate range, sometimes any 25-bit value.
    function automatic coord_t rand_coord();
        if ($urandom_range(0, 4) == 0)
            return coord_t'($urandom());
        return coord_t'(int'($urandom_range(0, 10999998)) - 999999);
    endfunction

    function automatic void add_vector(input logic [1:0] fn, input int x, y, z, serial,
                                       input bit has_want = 1'b0,
                                       input bit clashed = 1'b0, input int comps = 0,
                                       input longint ctot = 0, input longint ptot = 0);
        vector_row_t row;
        row.fn                = fn;
        row.x                 = x;
        row.y                 = y;
        row.z                 = z;
        row.serial            = serial;
        row.has_want          = has_want;
        row.want.clashed      = clashed;
        row.want.comparisons  = QCOMP_W'(comps);
        row.want.serial       = SERIAL_W'(serial);
        row.want.clash_total  = CLASH_TOT_W'(ctot);
        row.want.comp_total   = COMP_TOT_W'(ptot);
        vectors.insert(vectors.size(), row);
    endfunction

    // ------------------------------------------------------------------
    // Request side. Fields change only at a rising edge; valid drops only
    // when a wait is drawn or reports are drained, so it never falls and rises in one step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] fn, input coord_t x, y, z,
                             input serial_t serial, input bit has_want,
                             input clash_report_t want);
        int            gap;
        clash_report_t got;
        gap = draw_idle(tx_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.func        <= fn;
        req_ch.coord_x     <= x;
        req_ch.coord_y     <= y;
        req_ch.coord_z     <= z;
        req_ch.atom_serial <= serial;
        req_ch.valid       <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        // transfer happened at this edge
        if (predict_clash(fn, x, y, z, serial, got))
            pending_reports.insert(pending_reports.size(), has_want ? want : got);
    endtask

    task automatic send_noise();
        send_item(FUNC_UNUSED, rand_coord(), rand_coord(), rand_coord(),
                  serial_t'($urandom()), 1'b0, no_want);
    endtask

    // Hold the request side off until every outstanding query has reported.
    // Always takes at least one edge so valid is never re-raised in the same step.
    task automatic drain_reports();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
    endtask

    // Radius writes happen only with the block idle. A trailing clear or load
    // gives no report, so wait out a full query time before writing.
    task automatic set_radius(input logic [RADIUS_W-1:0] value);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.clash_radius <= value;
        cfg_ch.valid        <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        radius_m = value;
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure, check at each transfer.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [63:0] want, got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: serial %0d %s expected %0d actual %0d",
                     $time, rsp_ch.serial_echo, name, want, got);
        end
    endfunction

    task automatic check_report();
        clash_report_t want;
        if (pending_reports.size() == 0)
        begin
            mismatches++;
            $display("%0t: result with no query outstanding, expected none actual serial %0d",
                     $time, rsp_ch.serial_echo);
            return;
        end
        want = pending_reports.pop_front();
        check_field("clashed", 64'(want.clashed), 64'(rsp_ch.clashed));
        check_field("query_comparisons", 64'(want.comparisons),
                    64'(rsp_ch.query_comparisons));
        check_field("serial_echo", 64'(want.serial), 64'(rsp_ch.serial_echo));
        check_field("total_clashes", 64'(want.clash_total), 64'(rsp_ch.total_clashes));
        check_field("total_comparisons", 64'(want.comp_total),
                    64'(rsp_ch.total_comparisons));
    endtask

    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_idle(rx_calm);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
            check_report();
        end
    end

    // Watchdog: too long without any transfer on any channel means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int                  sent;
        int                  seg;
        int                  n_items;
        int                  spread;
        int                  pick;
        int                  idx;
        coord_t              cx;
        coord_t              cy;
        coord_t              cz;
        coord_t              qx;
        coord_t              qy;
        coord_t              qz;
        logic [RADIUS_W-1:0] value;

        req_ch.valid        = 1'b0;
        req_ch.func         = FUNC_CLEAR;
        req_ch.coord_x      = '0;
        req_ch.coord_y      = '0;
        req_ch.coord_z      = '0;
        req_ch.atom_serial  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.clash_radius = RADIUS_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed vectors, radius at its reset value of 4000 ---
        // query on the empty store right after reset
        add_vector(FUNC_QUERY, 0, 0, 0, 99999, 1'b1, 1'b0, 0, 0, 0);
        add_vector(FUNC_LOAD, 0, 0, 0, 0);
        // just inside the radius, then exactly on it (strict compare)
        add_vector(FUNC_QUERY, 3999, 0, 0, 1, 1'b1, 1'b1, 1, 1, 1);
        add_vector(FUNC_QUERY, 0, -4000, 0, 2, 1'b1, 1'b0, 1, 1, 2);
        // 25-bit extremes: widest possible coordinate difference
        add_vector(FUNC_LOAD, 16777215, 16777215, 16777215, 131071);
        add_vector(FUNC_LOAD, -16777216, -16777216, -16777216, 0);
        add_vector(FUNC_QUERY, -16777216, -16777216, -16777216, 3);
        add_vector(FUNC_QUERY, 16777215, 16777215, 16777215, 131071);
        // ends of the documented range
        add_vector(FUNC_LOAD, 9999999, -999999, 9999999, 5);
        add_vector(FUNC_LOAD, -999999, 9999999, -999999, 6);
        add_vector(FUNC_QUERY, -999999, 9999999, -999999, 99999);
        add_vector(FUNC_QUERY, 5000000, 5000000, 5000000, 0);
        // unused func code: no result, no state change
        add_vector(FUNC_UNUSED, 1, 2, 3, 7);
        add_vector(FUNC_QUERY, 0, 0, 0, 4);
        // clear empties the store and zeroes the totals
        add_vector(FUNC_CLEAR, -1, -1, -1, 131071);
        add_vector(FUNC_QUERY, 0, 0, 0, 5, 1'b1, 1'b0, 0, 0, 0);
        add_vector(FUNC_LOAD, 100, -200, 300, 0);
        add_vector(FUNC_QUERY, 100, -200, 300, 6, 1'b1, 1'b1, 1, 1, 1);

        foreach (vectors[i])
            send_item(vectors[i].fn, coord_t'(vectors[i].x), coord_t'(vectors[i].y),
                      coord_t'(vectors[i].z), serial_t'(vectors[i].serial),
                      vectors[i].has_want, vectors[i].want);

        // --- grid with 1e6 spacing so only one atom is ever near ---
        set_radius('0);
        send_item(FUNC_CLEAR, '0, '0, '0, '0, 1'b0, no_want);
        for (int i = 0; i < GRID_ATOMS; i++)
            send_item(FUNC_LOAD, coord_t'(-16000000 + (i % 32) * 1000000),
                      coord_t'(-16000000 + (i / 32) * 1000000), '0,
                      serial_t'(i), 1'b0, no_want);
        // zero radius: nothing ever clashes, not even at distance zero
        send_item(FUNC_QUERY, coord_t'(15000000), coord_t'(-15000000), '0,
                  serial_t'(1023), 1'b0, no_want);
        set_radius('1);
        // last stored atom, one short of the largest radius
        send_item(FUNC_QUERY, coord_t'(15000000 + 65534), coord_t'(-15000000), '0,
                  serial_t'(1024), 1'b0, no_want);
        // far corner away from every grid atom: must not clash
        send_item(FUNC_QUERY, coord_t'(16000000), coord_t'(16000000),
                  coord_t'(16000000), serial_t'(1025), 1'b0, no_want);

        // --- random traffic in segments: optional radius write and clear,
        //     a cluster of loads, then queries mostly aimed at stored atoms ---
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (seg % 3 == 0)
            begin
                case (seg / 3)
                    0:       value = '0;
                    1:       value = '1;
                    2:       value = 16'd1;
                    3:       value = RADIUS_RESET;
                    default: value = ($urandom_range(0, 1) == 0) ?
                                     16'($urandom_range(0, 8000)) : 16'($urandom());
                endcase
                set_radius(value);
            end
            else if ($urandom_range(0, 7) == 0)
                drain_reports();

            if (seg == 0 || $urandom_range(0, 3) == 0)
            begin
                send_item(FUNC_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                          serial_t'($urandom()), 1'b0, no_want);
                sent++;
            end

            spread = int'(radius_m) + 1;
            cx     = rand_coord();
            cy     = rand_coord();
            cz     = rand_coord();

            n_items = $urandom_range(0, 12);
            for (int k = 0; k < n_items; k++)
            begin
                send_item(FUNC_LOAD, coord_t'(cx + jitter(4 * spread)),
                          coord_t'(cy + jitter(4 * spread)), coord_t'(cz + jitter(4 * spread)),
                          serial_t'($urandom()), 1'b0, no_want);
                sent++;
                if ($urandom_range(0, 11) == 0)
                    send_noise();
            end

            n_items = $urandom_range(1, 4);
            for (int k = 0; k < n_items; k++)
            begin
                pick = $urandom_range(0, 9);
                if (atom_count > 0 && pick < 6)
                begin
                    // near a stored atom: roughly half land inside the sphere
                    idx = $urandom_range(0, atom_count - 1);
                    qx  = coord_t'(atom_x[idx] + jitter(spread));
                    qy  = coord_t'(atom_y[idx] + jitter(spread));
                    qz  = coord_t'(atom_z[idx] + jitter(spread));
                end
                else if (pick < 8)
                begin
                    qx = coord_t'(cx + jitter(4 * spread));
                    qy = coord_t'(cy + jitter(4 * spread));
                    qz = coord_t'(cz + jitter(4 * spread));
                end
                else
                begin
                    qx = rand_coord();
                    qy = rand_coord();
                    qz = rand_coord();
                end
                send_item(FUNC_QUERY, qx, qy, qz, serial_t'($urandom()), 1'b0, no_want);
                sent++;
                if ($urandom_range(0, 11) == 0)
                    send_noise();
            end
            seg++;
        end

        // --- wind down: all reports in, then watch for strays ---
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/acd_pkg.sv
rtl/core/acd_cfg_if.sv
rtl/core/acd_in_if.sv
rtl/core/acd_out_if.sv
rtl/core/acd_cell.sv
rtl/core/acd_dist.sv
rtl/core/atom_clash_detector_core.sv
rtl/core/acd_checker.sv
tb/tb_atom_clash_detector_core.sv
